@@ rtl/bfa_pkg.sv @@
// Shared constants, types and control structs of the best-fit block allocator.
package bfa_pkg;

	// Table geometry.
	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	// Fixed widths of the external fields.
	localparam int CMD_W   = 1;
	localparam int BIDX_W  = 4;
	localparam int SVAL_W  = 16;
	localparam int CNT_W   = 5;
	localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	localparam logic [CNT_W-1:0] CNT_RST = CNT_W'(16);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b1;

	// Search token that walks down the row of cells.
	typedef struct packed {
		logic                 valid;
		logic [SIZE_BITS-1:0] req;
		logic                 found;
		logic [SIZE_BITS-1:0] best_left;
		logic [IDX_W-1:0]     best_idx;
	} bfa_tok_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic                 load_we;
		logic [IDX_W-1:0]     load_idx;
		logic [SIZE_BITS-1:0] load_size;
		logic                 mark_we;
		logic [IDX_W-1:0]     mark_idx;
		logic [CNT_W-1:0]     count;
	} bfa_ctl_t;

endpackage

@@ rtl/bfa_in_if.sv @@
// Input channel carrying load and request items.
interface bfa_in_if;
	import bfa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BIDX_W-1:0] block_index;
	logic [SVAL_W-1:0] size_value;

	modport source (output valid, output command, output block_index, output size_value,
		input ready);
	modport sink (input valid, input command, input block_index, input size_value,
		output ready);
endinterface

@@ rtl/bfa_out_if.sv @@
// Output channel carrying allocation results.
interface bfa_out_if;
	import bfa_pkg::*;

	logic              valid;
	logic              ready;
	logic              granted;
	logic [BIDX_W-1:0] chosen_block;
	logic [SVAL_W-1:0] leftover;

	modport source (output valid, output granted, output chosen_block, output leftover,
		input ready);
	modport sink (input valid, input granted, input chosen_block, input leftover,
		output ready);
endinterface

@@ rtl/bfa_cell.sv @@
// One table cell: holds a block size and used mark and refines the passing search token.
module bfa_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfa_pkg::IDX_W-1:0] cell_idx,
	input  bfa_pkg::bfa_ctl_t         ctl,
	input  bfa_pkg::bfa_tok_t         tok_i,
	output bfa_pkg::bfa_tok_t         tok_o
);
	import bfa_pkg::*;

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;
	bfa_tok_t             tok_s1;
	bfa_tok_t             tok_d;
	logic                 sel_load;
	logic                 sel_mark;
	logic                 active;
	logic                 fits;
	logic                 take;
	logic [SIZE_BITS-1:0] left;

	assign sel_load = ctl.load_we && (ctl.load_idx == cell_idx);
	assign sel_mark = ctl.mark_we && (ctl.mark_idx == cell_idx);

	// Block size storage; undefined until the first load.
	always_ff @(posedge clk) begin
		if (sel_load) begin
			size_q <= ctl.load_size;
		end
	end

	// Used mark: a load frees the block, a grant claims it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (sel_load) begin
			used_q <= 1'b0;
		end else if (sel_mark) begin
			used_q <= 1'b1;
		end
	end

	// Compare this block against the best candidate seen so far.
	always_comb begin
		active = CMP_W'(cell_idx) < CMP_W'(ctl.count);
		fits   = tok_i.valid && active && !used_q && (size_q >= tok_i.req);
		left   = size_q - tok_i.req;
		take   = fits && (!tok_i.found || (left < tok_i.best_left));
	end

	// Refined token: this block replaces the candidate when it is a better fit.
	always_comb begin
		tok_d = tok_i;
		if (take) begin
			tok_d.found     = 1'b1;
			tok_d.best_left = left;
			tok_d.best_idx  = cell_idx;
		end
	end

	// Hand the refined token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_d;
		end
	end

	assign tok_o = tok_s1;

endmodule

@@ rtl/best_fit_block_allocator.sv @@
// Top level of the best-fit block allocator: row of table cells, control and result staging.
// A load gives no result. A request walks a token through NUM_BLOCKS cells, one per cycle,
// each of which registers it; its result leaves the last cell and is then registered in
// the output register. One request is in flight at a time. A new item is taken while a
// result waits in the output register, but not while one waits in the hold stage.
// Reset clears all used marks and sets blocks_in_use to 16; block sizes are undefined.
module best_fit_block_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bfa_pkg::CNT_W-1:0] cfg_wdata,
	bfa_in_if.sink                    in_ch,
	bfa_out_if.source                 out_ch
);
	import bfa_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              out_granted_q;
	logic [BIDX_W-1:0] out_chosen_q;
	logic [SVAL_W-1:0] out_left_q;
	logic              hold_granted_q;
	logic [BIDX_W-1:0] hold_chosen_q;
	logic [SVAL_W-1:0] hold_left_q;

	bfa_tok_t          tok [NUM_BLOCKS+1];
	logic [NUM_BLOCKS-1:0] tok_v;
	bfa_ctl_t          ctl;
	bfa_tok_t          tail;
	logic              acc;
	logic              load_acc;
	logic              req_acc;
	logic              out_free;
	logic              out_load;
	logic              res_granted;
	logic [BIDX_W-1:0] res_chosen;
	logic [SVAL_W-1:0] res_left;

	// Input handshake.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;
	assign load_acc    = acc && (in_ch.command == CMD_LOAD);
	assign req_acc     = acc && (in_ch.command == CMD_REQUEST);

	// Blocks-in-use register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RST;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	assign tail = tok[NUM_BLOCKS];

	// Control broadcast to the cells.
	always_comb begin
		ctl.load_we   = load_acc && (int'(in_ch.block_index) < NUM_BLOCKS);
		ctl.load_idx  = IDX_W'(in_ch.block_index);
		ctl.load_size = SIZE_BITS'(in_ch.size_value);
		ctl.mark_we   = tail.valid && tail.found;
		ctl.mark_idx  = tail.best_idx;
		ctl.count     = cnt_q;
	end

	// Fresh token entering the first cell.
	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = req_acc;
		tok[0].req       = SIZE_BITS'(in_ch.size_value);
	end

	// Row of cells.
	for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
		bfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(j)),
			.ctl      (ctl),
			.tok_i    (tok[j]),
			.tok_o    (tok[j+1])
		);
		assign tok_v[j] = tok[j+1].valid;
	end

	// Result fields from the token leaving the last cell.
	always_comb begin
		res_granted = tail.found;
		res_chosen  = tail.found ? BIDX_W'(tail.best_idx) : '0;
		res_left    = tail.found ? SVAL_W'(tail.best_left) : '0;
	end

	assign out_free = !out_valid_q || out_ch.ready;

	// The output register takes a finished or held result whenever it is free.
	assign out_load = out_free &&
		(((state_q == ST_SCAN) && tail.valid) || (state_q == ST_HOLD));

	// Sequencer, output register and hold stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			out_granted_q  <= 1'b0;
			out_chosen_q   <= '0;
			out_left_q     <= '0;
			hold_granted_q <= 1'b0;
			hold_chosen_q  <= '0;
			hold_left_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (state_q == ST_HOLD) begin
					out_granted_q <= hold_granted_q;
					out_chosen_q  <= hold_chosen_q;
					out_left_q    <= hold_left_q;
				end else begin
					out_granted_q <= res_granted;
					out_chosen_q  <= res_chosen;
					out_left_q    <= res_left;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.valid) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							hold_granted_q <= res_granted;
							hold_chosen_q  <= res_chosen;
							hold_left_q    <= res_left;
							state_q        <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.granted      = out_granted_q;
	assign out_ch.chosen_block = out_chosen_q;
	assign out_ch.leftover     = out_left_q;

	// At most one search token is anywhere in the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one search token in the cell row");

	// A token only leaves the row while the sequencer is scanning.
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == ST_SCAN))
		else $error("search token finished outside of a scan");

	// A request transfer starts a scan.
	a_req_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == ST_SCAN))
		else $error("request transfer did not start a scan");

	// A held result implies the output register is still occupied.
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> out_valid_q)
		else $error("result held while output register is free");

	// A refused request reports zero index and zero leftover.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_granted_q) |-> (out_chosen_q == '0 && out_left_q == '0))
		else $error("refused request carries nonzero fields");

endmodule
